// ===== hw/rtl/mesh_bounds_and_sphere_assert.svh =====
`ifndef MESH_BOUNDS_AND_SPHERE_ASSERT_SVH
`define MESH_BOUNDS_AND_SPHERE_ASSERT_SVH

// check that cons holds in the same cycle as ante
`define MBS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// check that cons holds in the cycle after ante
`define MBS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/mbs_pkg.sv =====
package mbs_pkg;

   localparam int MaxVertices = 4096;
   localparam int AddrW       = $clog2(MaxVertices);
   localparam int CountW      = AddrW + 1;
   localparam int CoordW      = 32;
   localparam int VertW       = 3 * CoordW;
   localparam int SumW        = CoordW + AddrW;
   localparam int RemW        = CountW + 1;
   localparam int MagW        = CoordW;
   localparam int SqW         = 2 * MagW;
   localparam int DistW       = SqW + 2;
   localparam int RootW       = 34;
   localparam int RadW        = 2 * RootW;
   localparam int SqRemW      = RootW + 2;
   localparam int RadiusW     = 33;
   localparam int StepW       = 6;
   localparam int RspW        = 328;

   // "infinity" bounds of an empty box
   localparam logic [CoordW-1:0] CoordPosMax = {1'b0, {(CoordW-1){1'b1}}};
   localparam logic [CoordW-1:0] CoordNegMin = {1'b1, {(CoordW-1){1'b0}}};

   typedef struct packed {
      logic [2:0][CoordW-1:0] min_c;
      logic [2:0][CoordW-1:0] max_c;
      logic [2:0][SumW-1:0]   sum;
      logic [CountW-1:0]      count;
   } job_type;

   typedef struct packed {
      logic             en;
      logic [AddrW-1:0] addr;
      logic [VertW-1:0] data;
   } wr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SCAN,
      ST_DRAIN,
      ST_SQRT,
      ST_OUTPUT
   } back_state_type;

endpackage

// ===== hw/rtl/mesh_bounds_and_sphere.sv =====
// Mesh bounds and bounding sphere.
// req channel: one vertex per beat, tdata = {z, y, x} as signed Q16.16 (x in
// bits 31:0), tlast on the final vertex of the mesh. Up to 4096 vertices are
// kept; later ones are dropped, but their tlast still closes the mesh.
// rsp channel: one beat per mesh, tdata from the lowest bit up: min x/y/z,
// max x/y/z, center x/y/z (32 bits each) and the 33-bit radius.
// Loading stores each accepted vertex in turn. After the tlast beat the back
// end runs the division for the centroid, the distance scan over the N stored
// vertices (one vertex read per cycle from the store) and the square root.
// req_tready drops from tlast until the result sits in the output register;
// the store has a single port pair shared by loading and scanning.
// A result waiting for rsp_tready holds the back end, but the front accepts
// the next mesh as soon as the result is registered.
// Reset clears the running box, sums and count; the vertex store is not
// cleared and needs no pass.
module mesh_bounds_and_sphere import mbs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [95:0]     req_tdata,   // pos_x, pos_y, pos_z
   input  logic            req_tlast,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [RspW-1:0] rsp_tdata    // box_min_x/y/z, box_max_x/y/z, center_x/y/z, radius
);

`include "mesh_bounds_and_sphere_assert.svh"

   logic    job_valid, job_pop, back_busy;
   job_type job;
   wr_type  wr;

   mbs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .back_busy  (back_busy),
      .job_pop    (job_pop),
      .job_valid  (job_valid),
      .job        (job),
      .wr         (wr)
   );

   mbs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .job_valid  (job_valid),
      .job        (job),
      .job_pop    (job_pop),
      .back_busy  (back_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `MBS_ASSERT_NOW(a_no_write_during_scan, wr.en, !back_busy && !job_valid)
   `MBS_ASSERT_NOW(a_stall_while_pending, job_valid, !req_tready)
   `MBS_ASSERT_NEXT(a_pop_starts_back, job_pop, back_busy && !job_valid)

endmodule

// ===== hw/rtl/mbs_front.sv =====
module mbs_front import mbs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [VertW-1:0]          req_tdata,
   input  logic                      req_tlast,
   input  logic                      back_busy,
   input  logic                      job_pop,
   output logic                      job_valid,
   output job_type                   job,
   output wr_type                    wr
);

   logic [CountW-1:0]        count_ff, count_in, count_nx;
   logic signed [CoordW-1:0] min_ff [3], min_in [3], min_nx [3];
   logic signed [CoordW-1:0] max_ff [3], max_in [3], max_nx [3];
   logic signed [SumW-1:0]   sum_ff [3], sum_in [3], sum_nx [3];
   logic signed [CoordW-1:0] pos [3];
   logic                     job_valid_ff, job_valid_in;
   job_type                  job_ff, job_in;
   logic                     accept, keep;

   assign req_tready = !job_valid_ff && !back_busy;
   assign job_valid  = job_valid_ff;
   assign job        = job_ff;

   always_comb begin
      accept       = req_tvalid && req_tready;
      keep         = accept && (count_ff < CountW'(MaxVertices));
      count_nx     = keep ? count_ff + 1'b1 : count_ff;
      job_valid_in = job_pop ? 1'b0 : job_valid_ff;
      job_in       = job_ff;
      for (int k = 0; k < 3; k++) begin
         pos[k]    = signed'(req_tdata[k*CoordW +: CoordW]);
         min_nx[k] = min_ff[k];
         max_nx[k] = max_ff[k];
         sum_nx[k] = sum_ff[k];
         if (keep) begin
            if (pos[k] < min_ff[k]) min_nx[k] = pos[k];
            if (pos[k] > max_ff[k]) max_nx[k] = pos[k];
            sum_nx[k] = sum_ff[k] + {{(SumW-CoordW){pos[k][CoordW-1]}}, pos[k]};
         end
         min_in[k] = min_nx[k];
         max_in[k] = max_nx[k];
         sum_in[k] = sum_nx[k];
      end
      count_in = count_nx;
      // hand the finished mesh to the back end and start over
      if (accept && req_tlast) begin
         job_valid_in = 1'b1;
         job_in.count = count_nx;
         for (int k = 0; k < 3; k++) begin
            job_in.min_c[k] = min_nx[k];
            job_in.max_c[k] = max_nx[k];
            job_in.sum[k]   = sum_nx[k];
            min_in[k]       = signed'(CoordPosMax);
            max_in[k]       = signed'(CoordNegMin);
            sum_in[k]       = '0;
         end
         count_in = '0;
      end
   end

   always_comb begin
      wr.en   = keep;
      wr.addr = count_ff[AddrW-1:0];
      wr.data = req_tdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         job_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            min_ff[k] <= signed'(CoordPosMax);
            max_ff[k] <= signed'(CoordNegMin);
            sum_ff[k] <= '0;
         end
      end else begin
         count_ff     <= count_in;
         job_valid_ff <= job_valid_in;
         for (int k = 0; k < 3; k++) begin
            min_ff[k] <= min_in[k];
            max_ff[k] <= max_in[k];
            sum_ff[k] <= sum_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

endmodule

// ===== hw/rtl/mbs_back.sv =====
module mbs_back import mbs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  wr_type          wr,
   input  logic            job_valid,
   input  job_type         job,
   output logic            job_pop,
   output logic            back_busy,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [RspW-1:0] rsp_tdata
);

   logic [VertW-1:0] mem [MaxVertices];

   back_state_type state_ff, state_in;
   job_type        job_ff;
   logic [StepW-1:0]  step_ff;
   logic [SumW-1:0]   num_ff [3];
   logic [RemW-1:0]   rem_ff [3];
   logic [CoordW-1:0] center_ff [3];
   logic [CountW-1:0] addr_ff;
   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [VertW-1:0]  rd_ff;
   logic [MagW-1:0]   mag_ff [3];
   logic [SqW-1:0]    sq_ff [3];
   logic [DistW-1:0]  dist_max_ff;
   logic [RadW-1:0]   rad_ff;
   logic [SqRemW-1:0] sqrem_ff;
   logic [RootW-1:0]  root_ff;
   logic              rsp_valid_ff;
   logic [RspW-1:0]   rsp_data_ff;

   logic              issue, div_last, sqrt_last, load_rsp, pipe_empty;
   logic [RemW-1:0]   div_r [3];
   logic              div_ge [3];
   logic [SumW-1:0]   num_nx [3];
   logic [CoordW-1:0] center_nx [3];
   logic [CoordW:0]   diff [3];
   logic [DistW-1:0]  dist_sum;
   logic [SqRemW+1:0] sq_r, sq_trial;
   logic              sq_ge;

   assign back_busy  = state_ff != ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      div_last   = step_ff == StepW'(SumW - 1);
      sqrt_last  = step_ff == StepW'(RootW - 1);
      pipe_empty = !s1_valid_ff && !s2_valid_ff && !s3_valid_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (job_valid) state_in = ST_DIVIDE;
         ST_DIVIDE: if (div_last) state_in = ST_SCAN;
         ST_SCAN:   if (addr_ff == job_ff.count) state_in = ST_DRAIN;
         ST_DRAIN:  if (pipe_empty) state_in = ST_SQRT;
         ST_SQRT:   if (sqrt_last) state_in = ST_OUTPUT;
         ST_OUTPUT: if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      job_pop  = state_ff == ST_IDLE && job_valid;
      issue    = state_ff == ST_SCAN && addr_ff != job_ff.count;
      load_rsp = state_ff == ST_OUTPUT && (!rsp_valid_ff || rsp_tready);
   end

   // one restoring-division step per axis per cycle, the scan differences and the square-root trial
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         div_r[k]     = {rem_ff[k][RemW-2:0], num_ff[k][SumW-1]};
         div_ge[k]    = div_r[k] >= {1'b0, job_ff.count};
         num_nx[k]    = {num_ff[k][SumW-2:0], div_ge[k]};
         center_nx[k] = job_ff.sum[k][SumW-1] ? CoordW'(-num_nx[k]) : num_nx[k][CoordW-1:0];
         diff[k] = {rd_ff[k*CoordW+CoordW-1], rd_ff[k*CoordW +: CoordW]}
                 - {center_ff[k][CoordW-1], center_ff[k]};
      end
      dist_sum = DistW'(sq_ff[0]) + DistW'(sq_ff[1]) + DistW'(sq_ff[2]);
      sq_r     = {sqrem_ff, rad_ff[RadW-1 -: 2]};
      sq_trial = {2'b00, root_ff, 2'b01};
      sq_ge    = sq_r >= sq_trial;
   end

   always_ff @(posedge clock) begin
      if (wr.en) mem[wr.addr] <= wr.data;
      rd_ff <= mem[addr_ff[AddrW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop || state_ff == ST_DRAIN) step_ff <= '0;
      else step_ff <= step_ff + 1'b1;
      if (job_pop) begin
         job_ff      <= job;
         dist_max_ff <= '0;
         for (int k = 0; k < 3; k++) begin
            num_ff[k] <= job.sum[k][SumW-1] ? -job.sum[k] : job.sum[k];
            rem_ff[k] <= '0;
         end
      end
      if (state_ff == ST_DIVIDE) begin
         for (int k = 0; k < 3; k++) begin
            num_ff[k] <= num_nx[k];
            rem_ff[k] <= div_ge[k] ? div_r[k] - {1'b0, job_ff.count} : div_r[k];
            if (div_last) center_ff[k] <= center_nx[k];
         end
         addr_ff <= '0;
      end
      if (issue) addr_ff <= addr_ff + 1'b1;
      for (int k = 0; k < 3; k++) begin
         mag_ff[k] <= diff[k][CoordW] ? MagW'(-diff[k]) : diff[k][MagW-1:0];
         sq_ff[k]  <= mag_ff[k] * mag_ff[k];
      end
      if (s3_valid_ff && dist_sum > dist_max_ff) dist_max_ff <= dist_sum;
      if (state_ff == ST_DRAIN) begin
         rad_ff   <= RadW'(dist_max_ff);
         sqrem_ff <= '0;
         root_ff  <= '0;
      end
      // one root bit per cycle, two radicand bits consumed
      if (state_ff == ST_SQRT) begin
         rad_ff   <= {rad_ff[RadW-3:0], 2'b00};
         sqrem_ff <= sq_ge ? SqRemW'(sq_r - sq_trial) : SqRemW'(sq_r);
         root_ff  <= {root_ff[RootW-2:0], sq_ge};
      end
      if (load_rsp) begin
         rsp_data_ff <= {(RspW-9*CoordW-RadiusW)'(0), root_ff[RadiusW-1:0],
                         center_ff[2], center_ff[1], center_ff[0],
                         job_ff.max_c[2], job_ff.max_c[1], job_ff.max_c[0],
                         job_ff.min_c[2], job_ff.min_c[1], job_ff.min_c[0]};
      end
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import mbs_pkg::*;

   localparam int CycleLimit = 3000000;
   localparam int HoldCycles = 600;

   typedef struct packed {
      logic [31:0] min_x, min_y, min_z;
      logic [31:0] max_x, max_y, max_z;
      logic [31:0] cen_x, cen_y, cen_z;
      logic [32:0] radius;
   } bounds_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [95:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RspW-1:0] rsp_tdata;

   mesh_bounds_and_sphere u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // predictor state for the mesh being loaded
   logic signed [31:0] mesh_x [MaxVertices];
   logic signed [31:0] mesh_y [MaxVertices];
   logic signed [31:0] mesh_z [MaxVertices];
   int mesh_n = 0;
   logic signed [63:0] acc_x = 0, acc_y = 0, acc_z = 0;
   logic signed [31:0] lo_x = CoordPosMax, lo_y = CoordPosMax, lo_z = CoordPosMax;
   logic signed [31:0] hi_x = CoordNegMin, hi_y = CoordNegMin, hi_z = CoordNegMin;

   bounds_type expected_bounds [$];
   int mismatch_count = 0;
   int cycle_count = 0;
   bit long_hold = 1'b0;
   int burst_max = 6;
   int gap_max = 4;

   function automatic logic [32:0] floor_root(logic [66:0] v);
      logic [33:0] r;
      logic [33:0] c;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
         c = r | (34'd1 << b);
         if ({67'd0, c} * {67'd0, c} <= {67'd0, v}) r = c;
      end
      return r[32:0];
   endfunction

   task automatic predict_vertex(logic signed [31:0] x, y, z, logic last);
      logic signed [63:0] cx, cy, cz, dx, dy, dz;
      logic [66:0] dist_sq, best;
      bounds_type b;
      if (mesh_n < MaxVertices) begin
         mesh_x[mesh_n] = x; mesh_y[mesh_n] = y; mesh_z[mesh_n] = z;
         if (x < lo_x) lo_x = x;
         if (y < lo_y) lo_y = y;
         if (z < lo_z) lo_z = z;
         if (x > hi_x) hi_x = x;
         if (y > hi_y) hi_y = y;
         if (z > hi_z) hi_z = z;
         acc_x += x; acc_y += y; acc_z += z;
         mesh_n++;
      end
      if (!last) return;
      // SV signed division truncates toward zero
      cx = acc_x / mesh_n; cy = acc_y / mesh_n; cz = acc_z / mesh_n;
      best = '0;
      for (int i = 0; i < mesh_n; i++) begin
         dx = mesh_x[i] - cx; dy = mesh_y[i] - cy; dz = mesh_z[i] - cz;
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         if (dz < 0) dz = -dz;
         dist_sq = 67'(dx) * 67'(dx) + 67'(dy) * 67'(dy) + 67'(dz) * 67'(dz);
         if (dist_sq > best) best = dist_sq;
      end
      b.min_x = lo_x; b.min_y = lo_y; b.min_z = lo_z;
      b.max_x = hi_x; b.max_y = hi_y; b.max_z = hi_z;
      b.cen_x = cx[31:0]; b.cen_y = cy[31:0]; b.cen_z = cz[31:0];
      b.radius = floor_root(best);
      expected_bounds.insert(expected_bounds.size(), b);
      mesh_n = 0;
      acc_x = 0; acc_y = 0; acc_z = 0;
      lo_x = CoordPosMax; lo_y = CoordPosMax; lo_z = CoordPosMax;
      hi_x = CoordNegMin; hi_y = CoordNegMin; hi_z = CoordNegMin;
   endtask

   // sender gaps: bursts of random length, then random idle cycles
   int burst_left = 0;
   task automatic send_vertex(logic [31:0] x, y, z, logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, burst_max);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {z, y, x};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_vertex(x, y, z, last);
      burst_left--;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_bounds.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] any_coord();
      case ($urandom_range(0, 5))
         0: return CoordPosMax;
         1: return CoordNegMin;
         2: return $urandom_range(0, 2000) - 1000;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_extremes();
      send_vertex(CoordPosMax, CoordPosMax, CoordPosMax, 1'b1);
      send_vertex(CoordNegMin, CoordNegMin, CoordNegMin, 1'b1);
      send_vertex(CoordNegMin, CoordPosMax, 32'd0, 1'b0);
      send_vertex(CoordPosMax, CoordNegMin, 32'hffff_ffff, 1'b1);
      send_vertex(32'hffff_ffff, 32'd1, 32'h0001_0000, 1'b0);
      send_vertex(32'd2, 32'hffff_fffe, 32'd0, 1'b0);
      send_vertex(32'd0, 32'd0, 32'hfffe_0000, 1'b1);
      // negative sums not divisible by the count: centroid truncation toward zero
      send_vertex(-32'sd7, -32'sd5, 32'sd7, 1'b0);
      send_vertex(32'sd0, 32'sd0, 32'sd0, 1'b0);
      send_vertex(32'sd0, 32'sd1, -32'sd1, 1'b1);
      for (int i = 0; i < 6; i++)
         send_vertex(i[0] ? CoordPosMax : CoordNegMin, $urandom, $urandom, i == 5);
      send_vertex(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 1'b1);
      wait_drained();
   endtask

   task automatic test_random_meshes(int vertex_total);
      int sent = 0;
      int len;
      while (sent < vertex_total) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         for (int i = 0; i < len; i++)
            send_vertex(any_coord(), any_coord(), any_coord(), i == len - 1);
         sent += len;
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      long_hold = 1'b1;
      for (int m = 0; m < 6; m++)
         for (int i = 0; i < 3; i++)
            send_vertex($urandom, $urandom, $urandom, i == 2);
      long_hold = 1'b0;
      wait_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_random_meshes(200);
      test_backpressure();
      burst_max = 40; gap_max = 0;
      test_random_meshes(200);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && expected_bounds.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // receiver: stall pattern of its own, or one long counted hold when asked
   int stall_phase = 0;
   int hold_count = 0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (long_hold && hold_count < HoldCycles) begin
         hold_count <= hold_count + 1;
         rsp_tready <= 1'b0;
      end else if (stall_phase[9]) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      bounds_type got, want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '0;
         got.min_x = rsp_tdata[31:0];    got.min_y = rsp_tdata[63:32];
         got.min_z = rsp_tdata[95:64];   got.max_x = rsp_tdata[127:96];
         got.max_y = rsp_tdata[159:128]; got.max_z = rsp_tdata[191:160];
         got.cen_x = rsp_tdata[223:192]; got.cen_y = rsp_tdata[255:224];
         got.cen_z = rsp_tdata[287:256]; got.radius = rsp_tdata[320:288];
         if (expected_bounds.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result beat %h", got);
         end else begin
            want = expected_bounds.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("bounds mismatch: expected %h actual %h", want, got);
            end
         end
      end
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mbs_pkg.sv
hw/rtl/mbs_front.sv
hw/rtl/mbs_back.sv
hw/rtl/mesh_bounds_and_sphere.sv
tb/tb.sv
